// ===== src/pwd_pkg.sv =====
// Package for the pixel hit word decoder: item types, queue record and word constants.
// No dependencies; used by every module of the decoder.
`timescale 1ns / 1ps
`default_nettype none
package pwd_pkg;

  localparam logic [1:0]  TAG_TYPE     = 2'b01;
  localparam logic [31:0] SYNTH_TAG    = 32'hDEADBEEF;
  localparam logic [3:0]  TOT_NONE     = 4'hF;
  localparam logic [3:0]  TOT_ZERO     = 4'h0;
  localparam logic        KIND_HEADER  = 1'b0;
  localparam logic        KIND_HIT     = 1'b1;

  localparam int PEND_HDR  = 2;
  localparam int PEND_HIT0 = 1;
  localparam int PEND_HIT1 = 0;

  typedef struct packed {
    logic [31:0] word;
    logic        container_start;
    logic        batch_start;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] event_tag;
    logic [31:0] l1_count;
    logic [22:0] crossing_id;
    logic [6:0]  pixel_row;
    logic [6:0]  pixel_col;
    logic [3:0]  tot_value;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  pend;
    logic [31:0] hdr_tag;
    logic [31:0] l1;
    logic [22:0] crossing;
    logic [6:0]  row0;
    logic [6:0]  row1;
    logic [6:0]  col;
    logic [3:0]  tot0;
    logic [3:0]  tot1;
  } job_t;

endpackage
`default_nettype wire

// ===== src/pwd_front.sv =====
// Front end of the decoder: accepts words, keeps tag/L1/crossing/header state, builds jobs.
// Depends on pwd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pwd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire pwd_pkg::in_item_t in_item,
  output logic                  push,
  output pwd_pkg::job_t         push_job,
  input  wire logic             q_full
);

  logic [23:0] tag_r, tag_nxt;
  logic [31:0] l1_r, l1_nxt;
  logic [22:0] cross_r, cross_nxt;
  logic        seen_r, seen_nxt;

  logic        accept;
  logic [31:0] w;
  logic [23:0] tag_eff;
  logic [31:0] l1_eff, l1_new;
  logic [22:0] cross_eff, id;
  logic        seen_eff;
  logic        is_tag, is_err, is_ts, is_hit, keep;
  logic [23:0] diff;
  logic        step;
  logic [3:0]  tot0, tot1;
  logic [5:0]  row;
  logic [6:0]  row1, row0, col;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign w        = in_item.word;

  always_comb begin
    tag_eff   = in_item.batch_start ? 24'd0 : tag_r;
    l1_eff    = in_item.batch_start ? 32'd0 : l1_r;
    cross_eff = in_item.batch_start ? 23'd0 : cross_r;
    seen_eff  = in_item.container_start ? 1'b0 : seen_r;

    is_tag = (w[25:24] == pwd_pkg::TAG_TYPE);
    is_err = !is_tag && (w == pwd_pkg::SYNTH_TAG);
    is_ts  = !is_tag && !is_err && w[23];
    is_hit = !is_tag && !is_err && !w[23];

    id     = w[22:0];
    diff   = {1'b0, id} - {1'b0, cross_eff};
    step   = !diff[23] && (diff[22:0] > 23'd1);
    l1_new = l1_eff + {31'd0, step};

    tot0 = w[7:4];
    tot1 = w[3:0];
    row  = w[16:11];
    keep = !((tot0 == pwd_pkg::TOT_NONE) && (tot1 == pwd_pkg::TOT_NONE)) &&
           !((tot0 == pwd_pkg::TOT_ZERO) && (tot1 == pwd_pkg::TOT_ZERO));
    col  = {1'b0, w[20:17], 2'b00} + {5'd0, row[5], 1'b0} + (w[10] ? 7'd1 : 7'd2);
    if (!row[5]) begin
      row1 = ({2'b00, row[4:0]} + 7'd1) << 1;
    end else begin
      row1 = 7'd64 - {1'b0, row[4:0], 1'b0};
    end
    row0 = row1 - 7'd1;

    push_job.pend[pwd_pkg::PEND_HDR]  = is_ts || (is_hit && keep && !seen_eff);
    push_job.pend[pwd_pkg::PEND_HIT0] = is_hit && keep && (tot0 != pwd_pkg::TOT_NONE);
    push_job.pend[pwd_pkg::PEND_HIT1] = is_hit && keep && (tot1 != pwd_pkg::TOT_NONE);
    push_job.hdr_tag  = is_ts ? {8'd0, tag_eff} : pwd_pkg::SYNTH_TAG;
    push_job.l1       = is_ts ? l1_new : l1_eff;
    push_job.crossing = is_ts ? id : cross_eff;
    push_job.row0     = row0;
    push_job.row1     = row1;
    push_job.col      = col;
    push_job.tot0     = tot0;
    push_job.tot1     = tot1;

    push = accept && (|push_job.pend);

    tag_nxt   = tag_r;
    l1_nxt    = l1_r;
    cross_nxt = cross_r;
    seen_nxt  = seen_r;
    if (accept) begin
      tag_nxt   = is_tag ? w[23:0] : tag_eff;
      l1_nxt    = is_ts ? l1_new : l1_eff;
      cross_nxt = is_ts ? id : cross_eff;
      seen_nxt  = seen_eff || push_job.pend[pwd_pkg::PEND_HDR];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r   <= 24'd0;
      l1_r    <= 32'd0;
      cross_r <= 23'd0;
      seen_r  <= 1'b0;
    end else begin
      tag_r   <= tag_nxt;
      l1_r    <= l1_nxt;
      cross_r <= cross_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/pwd_queue.sv =====
// Job queue between front and back end of the decoder.
// Depends on pwd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pwd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pwd_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               q_valid,
  output pwd_pkg::job_t      q_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  pwd_pkg::job_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign q_valid = (cnt_r != '0);
  assign q_job   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ===== src/pwd_back.sv =====
// Back end of the decoder: expands one job into header and hit items, output register.
// Depends on pwd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pwd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire pwd_pkg::job_t q_job,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output pwd_pkg::out_item_t out_item
);

  pwd_pkg::job_t      job_r, job_nxt;
  logic [2:0]         pend_r, pend_nxt, remain;
  logic               out_valid_r, out_valid_nxt;
  pwd_pkg::out_item_t out_r, out_nxt;
  logic               load_out, have, emit;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    load_out = !out_valid_r || !out_stall;
    have     = |pend_r;
    emit     = have && load_out;

    out_nxt.l1_count    = job_r.l1;
    out_nxt.crossing_id = job_r.crossing;
    remain              = pend_r;
    if (pend_r[pwd_pkg::PEND_HDR]) begin
      remain[pwd_pkg::PEND_HDR] = 1'b0;
      out_nxt.kind      = pwd_pkg::KIND_HEADER;
      out_nxt.event_tag = job_r.hdr_tag;
      out_nxt.pixel_row = 7'd0;
      out_nxt.pixel_col = 7'd0;
      out_nxt.tot_value = 4'd0;
    end else if (pend_r[pwd_pkg::PEND_HIT0]) begin
      remain[pwd_pkg::PEND_HIT0] = 1'b0;
      out_nxt.kind      = pwd_pkg::KIND_HIT;
      out_nxt.event_tag = 32'd0;
      out_nxt.pixel_row = job_r.row0;
      out_nxt.pixel_col = job_r.col;
      out_nxt.tot_value = job_r.tot0;
    end else begin
      remain[pwd_pkg::PEND_HIT1] = 1'b0;
      out_nxt.kind      = pwd_pkg::KIND_HIT;
      out_nxt.event_tag = 32'd0;
      out_nxt.pixel_row = job_r.row1;
      out_nxt.pixel_col = job_r.col;
      out_nxt.tot_value = job_r.tot1;
    end
    out_nxt.last = (remain == 3'd0);

    pop = q_valid && (!have || (emit && (remain == 3'd0)));

    job_nxt  = pop ? q_job : job_r;
    pend_nxt = pop ? q_job.pend : (emit ? remain : pend_r);
    out_valid_nxt = load_out ? emit : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (emit) begin
      out_r <= out_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/pixel_hit_word_decoder_core.sv =====
// Top level of the pixel hit word decoder: front end, job queue and back end.
// Depends on pwd_pkg, pwd_front, pwd_queue and pwd_back.
//
//   port group  direction  payload      handshake
//   in_*        in         in_item_t    in_valid / in_stall
//   out_*       out        out_item_t   out_valid / out_stall
//
// One word is taken per cycle while the job queue has room; words that give no item
// (tag, error, filtered hits) never reach the queue.
// The back end sends one item per cycle while out_stall is low, and the front end keeps taking
// words into the queue while earlier ones are still being expanded. A taken word goes through
// the queue memory, then the back end's job register, then the output register.
// Reset is synchronous and empties the queue and clears tag, L1 counter, crossing id and flags.
// in_stall rises only when the queue is full; out_stall holds the output register.
`timescale 1ns / 1ps
`default_nettype none
module pixel_hit_word_decoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pwd_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pwd_pkg::out_item_t      out_item
);

  logic          push, q_full, pop, q_valid;
  pwd_pkg::job_t push_job, q_job;

  pwd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  pwd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  pwd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
